// File: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define XSFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xsfb assertion failed");

// next-cycle implication, checked out of reset
`define XSFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xsfb assertion failed");

`else

`define XSFB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define XSFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/xsfb_pkg.sv
// shared types and constants of the xor sprite framebuffer
package xsfb_pkg;

  localparam int ROW_BITS          = 64;  // stored bits per row
  localparam int LANES             = 8;   // sprite pixels per draw
  localparam int COL_IDX_W         = 6;   // index into a stored row
  localparam int COL_SUM_W         = 7;   // cursor column plus lane offset
  localparam int DEF_SCREEN_WIDTH  = 64;
  localparam int DEF_SCREEN_HEIGHT = 32;

  // what one pixel lane reports to the merge stage
  typedef struct packed {
    logic                 flip;  // pixel is set and on screen
    logic                 hit;   // pixel was already lit
    logic [COL_IDX_W-1:0] col;   // target column
  } lane_res_t;

endpackage

// File: sv/xor_sprite_row_framebuffer_unit.sv
// top level of the one-bit-per-pixel xor sprite framebuffer
// The block keeps a SCREEN_HEIGHT by SCREEN_WIDTH monochrome frame, one row per memory
// word, plus a cursor. Each input beat carries a kind: set position latches the cursor
// (x modulo the width, y modulo the height), draw xors an 8-pixel pattern into the
// cursor row with the pattern msb at the cursor column and pixels past the right edge
// dropped, clear zeroes the frame, and read row returns row pos_y modulo the height.
// Every input beat yields exactly one output beat: collision is set only by a draw that
// turned a lit pixel off, row_pixels carries data only for read row, bit i being
// column i. The row memory is read with a registered port at the acceptance edge,
// then eight pixel lanes plus a merge stage work on the registered row, which is
// written back when a draw completes, so in_ready returns the cycle after an item
// completes. An item completes only when the output register is free, and in_ready
// does not wait for the output beat to be taken, so one result may sit in the output
// register while the next item is accepted. Clear takes no sweep: each row has a
// valid bit that reset and clear drop at once, and a row that is not valid reads as
// zero.
`include "assert_macros.svh"

module xor_sprite_row_framebuffer_unit #(
  parameter int SCREEN_WIDTH  = xsfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = xsfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  input  logic [7:0]  in_pattern,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_collision,
  output logic [63:0] out_row_pixels
);

  localparam int COL_W = $clog2(SCREEN_WIDTH);
  localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

  // item kinds
  localparam logic [1:0] KIND_SET_POS = 2'd0;
  localparam logic [1:0] KIND_DRAW    = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_READ    = 2'd3;

  // modulo tables for the 8-bit coordinates, built at elaboration
  logic [COL_W-1:0] x_mod_tab [256];
  logic [ROW_W-1:0] y_mod_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_mod_tab
    assign x_mod_tab[g] = COL_W'(g % SCREEN_WIDTH);
    assign y_mod_tab[g] = ROW_W'(g % SCREEN_HEIGHT);
  end

  // item register and cursor
  logic             item_vld_r,  item_vld_nxt;
  logic [1:0]       item_kind_r;
  logic [COL_W-1:0] item_col_r;
  logic [ROW_W-1:0] item_row_r;
  logic [7:0]       item_pat_r;
  logic [COL_W-1:0] cursor_col_r, cursor_col_nxt;
  logic [ROW_W-1:0] cursor_row_r, cursor_row_nxt;

  // output register
  logic                          out_vld_r, out_vld_nxt;
  logic                          out_collision_r, out_collision_nxt;
  logic [xsfb_pkg::ROW_BITS-1:0] out_row_r, out_row_nxt;

  logic                          accept;
  logic                          done;
  logic                          rd_en;
  logic [ROW_W-1:0]              rd_addr;
  logic [xsfb_pkg::ROW_BITS-1:0] rd_data;
  logic                          wr_en;
  logic                          clr;
  logic [xsfb_pkg::ROW_BITS-1:0] new_row;
  logic                          draw_hit;

  xsfb_pkg::lane_res_t [xsfb_pkg::LANES-1:0] lanes;

  // one item in flight; it finishes once the output register can take its result
  assign in_ready = !item_vld_r;
  assign accept   = in_valid & in_ready;
  assign done     = item_vld_r & (!out_vld_r | out_ready);

  // draw reads the cursor row, read row reads the requested row
  assign rd_en   = accept & ((in_kind == KIND_DRAW) | (in_kind == KIND_READ));
  assign rd_addr = (in_kind == KIND_DRAW) ? cursor_row_r : y_mod_tab[in_pos_y];

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind_r <= in_kind;
      item_col_r  <= x_mod_tab[in_pos_x];
      item_row_r  <= y_mod_tab[in_pos_y];
      item_pat_r  <= in_pattern;
    end
  end

  xsfb_rowstore #(
    .DEPTH (SCREEN_HEIGHT),
    .AW    (ROW_W)
  ) u_rowstore (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (cursor_row_r),
    .wr_data (new_row),
    .clr     (clr)
  );

  // one lane per pattern pixel, msb at the cursor column
  for (genvar i = 0; i < xsfb_pkg::LANES; i++) begin : g_lane
    xsfb_lane #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .COL_W        (COL_W),
      .LANE         (i)
    ) u_lane (
      .cursor_col (cursor_col_r),
      .pat_bit    (item_pat_r[xsfb_pkg::LANES-1-i]),
      .row        (rd_data),
      .res        (lanes[i])
    );
  end

  xsfb_merge u_merge (
    .row       (rd_data),
    .lanes     (lanes),
    .new_row   (new_row),
    .collision (draw_hit)
  );

  // completion: state update and result for the pending item
  always_comb begin
    item_vld_nxt      = item_vld_r;
    cursor_col_nxt    = cursor_col_r;
    cursor_row_nxt    = cursor_row_r;
    out_vld_nxt       = out_vld_r & !out_ready;
    out_collision_nxt = out_collision_r;
    out_row_nxt       = out_row_r;
    wr_en             = 1'b0;
    clr               = 1'b0;
    if (done) begin
      item_vld_nxt      = 1'b0;
      out_vld_nxt       = 1'b1;
      out_collision_nxt = 1'b0;
      out_row_nxt       = '0;
      unique case (item_kind_r)
        KIND_SET_POS: begin
          cursor_col_nxt = item_col_r;
          cursor_row_nxt = item_row_r;
        end
        KIND_DRAW: begin
          wr_en             = 1'b1;
          out_collision_nxt = draw_hit;
        end
        KIND_CLEAR: begin
          clr = 1'b1;
        end
        KIND_READ: begin
          out_row_nxt = rd_data;
        end
        default: begin
          out_row_nxt = '0;
        end
      endcase
    end
    if (accept) begin
      item_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else begin
      item_vld_r   <= item_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_collision_r <= out_collision_nxt;
    out_row_r       <= out_row_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_collision  = out_collision_r;
  assign out_row_pixels = out_row_r;

  // an accepted beat blocks the input until it completes
  `XSFB_ASSERT_NEXT(a_accept_holds, clk, rst_n, accept, item_vld_r && !in_ready)
  // a completed item always shows up on the output the next cycle
  `XSFB_ASSERT_NEXT(a_done_to_out, clk, rst_n, done, out_vld_r)
  // the row read never overlaps a write-back or a clear
  `XSFB_ASSERT_IMPL(a_rd_no_wr, clk, rst_n, rd_en, !wr_en && !clr)
  // a collision result never carries row data
  `XSFB_ASSERT_IMPL(a_hit_no_row, clk, rst_n, out_vld_r && out_collision_r, out_row_r == '0)

endmodule

// File: sv/xsfb_lane.sv
// one sprite pixel lane: column, clipping and collision for a single pattern bit
module xsfb_lane #(
  parameter int SCREEN_WIDTH = xsfb_pkg::DEF_SCREEN_WIDTH,
  parameter int COL_W        = 6,
  parameter int LANE         = 0
) (
  input  logic [COL_W-1:0]             cursor_col,
  input  logic                         pat_bit,
  input  logic [xsfb_pkg::ROW_BITS-1:0] row,
  output xsfb_pkg::lane_res_t          res
);

  logic [xsfb_pkg::COL_SUM_W-1:0] col_sum;
  logic                           on_screen;

  assign col_sum   = xsfb_pkg::COL_SUM_W'(cursor_col) + xsfb_pkg::COL_SUM_W'(LANE);
  // clip at the right edge, no wrap
  assign on_screen = col_sum < xsfb_pkg::COL_SUM_W'(SCREEN_WIDTH);

  always_comb begin
    res.col  = col_sum[xsfb_pkg::COL_IDX_W-1:0];
    res.flip = pat_bit & on_screen;
    res.hit  = pat_bit & on_screen & row[col_sum[xsfb_pkg::COL_IDX_W-1:0]];
  end

endmodule

// File: sv/xsfb_merge.sv
// merge stage: folds the lane flips into the row and ors the collisions
module xsfb_merge (
  input  logic [xsfb_pkg::ROW_BITS-1:0]              row,
  input  xsfb_pkg::lane_res_t [xsfb_pkg::LANES-1:0]  lanes,
  output logic [xsfb_pkg::ROW_BITS-1:0]              new_row,
  output logic                                       collision
);

  logic [xsfb_pkg::ROW_BITS-1:0] flip_mask;

  always_comb begin
    flip_mask = '0;
    collision = 1'b0;
    for (int i = 0; i < xsfb_pkg::LANES; i++) begin
      if (lanes[i].flip) begin
        flip_mask[lanes[i].col] = 1'b1;
      end
      collision = collision | lanes[i].hit;
    end
  end

  assign new_row = row ^ flip_mask;

endmodule

// File: sv/xsfb_rowstore.sv
// row memory with registered read and per-row valid bits for instant clear
module xsfb_rowstore #(
  parameter int DEPTH = xsfb_pkg::DEF_SCREEN_HEIGHT,
  parameter int AW    = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [xsfb_pkg::ROW_BITS-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [xsfb_pkg::ROW_BITS-1:0] wr_data,
  input  logic                          clr
);

  logic [xsfb_pkg::ROW_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]              row_vld_r;
  logic [DEPTH-1:0]              row_vld_nxt;
  logic [xsfb_pkg::ROW_BITS-1:0] rd_data_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  // a row never written since reset or clear reads as zero
  always_comb begin
    row_vld_nxt = row_vld_r;
    if (clr) begin
      row_vld_nxt = '0;
    end else if (wr_en) begin
      row_vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else begin
      row_vld_r <= row_vld_nxt;
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule
